// ===== rtl/fixed_block_pool_allocator_top_assert.svh =====
// Assertion macros for the pool allocator checker
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_TOP_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define FBPA_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fbpa check failed");

// next-cycle implication, sampled on clk, off while in reset
`define FBPA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fbpa check failed");

`endif

// ===== rtl/fbpa_pkg.sv =====
// Types and constants shared by the pool allocator files
`timescale 1ns / 1ps

package fbpa_pkg;

    localparam int CHUNK_W   = 13;
    localparam int COUNT_W   = 9;
    localparam int ADDR_W    = 32;
    localparam int PADDR_W   = 4;

    localparam logic [CHUNK_W-1:0] CHUNK_MAX  = 13'd4096;

    localparam logic [CHUNK_W-1:0] CHUNK_RST  = 13'd64;
    localparam logic [COUNT_W-1:0] COUNT_RST  = 9'd256;

    // request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_POOL_BASE   = 2'd0;
    localparam logic [1:0] REG_CHUNK_BYTES = 2'd1;
    localparam logic [1:0] REG_POOL_CHUNKS = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_EXHAUSTED = 2'd2,
        ST_BAD_ADDR  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_CALC,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic               kind;
        logic [CHUNK_W-1:0] req_size;
        logic [ADDR_W-1:0]  address;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [ADDR_W-1:0]  granted_address;
    } rsp_t;

endpackage

// ===== rtl/fixed_block_pool_allocator_top.sv =====
// Fixed-size block pool allocator with a LIFO free list
`timescale 1ns / 1ps

// Usage
//   req channel (req_valid/req_ready/req): one request per handshake, either
//   an allocate (kind 0, req_size) or a free (kind 1, address).
//   rsp channel (rsp_valid/rsp_ready/rsp): at most one response per request,
//   status plus the granted user address (zero unless an allocate succeeds).
//   APB port: pool_base at 0x0, chunk_bytes at 0x4, pool_chunks at 0x8;
//   writing chunk_bytes or pool_chunks re-links the free list.
// Sequencing (one shared 33-bit add/subtract unit, one step a cycle)
//   Allocate: shift-add of head*chunk, one step per bit of the chunk index;
//   the response loads from S_FINISH once the output register is free.
//   Free: overflow step plus log2(MAX_CHUNKS) restoring-divide steps; an
//   address whose quotient overflows QW bits ends after the overflow step.
//   Size and exhaustion failures skip S_CALC and load from S_FINISH.
//   req_ready is high only while the sequencer is idle.
// Reset and relink (APB writes are taken as ever)
//   After reset and after each relink write a sweep writes every link entry
//   with req_ready low; an unanswered request in the sequencer is dropped.
// Stall
//   The response sits in an output register; a new request can be accepted
//   while it waits. A second response waits in the sequencer until taken.
module fixed_block_pool_allocator_top
    import fbpa_pkg::*;
#(
    parameter int MAX_CHUNKS   = 256,
    parameter int HEADER_BYTES = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  req_t               req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output rsp_t               rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // index widths: QW addresses a chunk, IDX_W also holds the null link
    localparam int QW     = $clog2(MAX_CHUNKS);
    localparam int IDX_W  = QW + 1;
    localparam int STEP_W = $clog2(QW + 1);
    localparam int CMP_W  = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;

    localparam logic [IDX_W-1:0]   NULL_LINK  = IDX_W'(MAX_CHUNKS);
    localparam logic [QW-1:0]      SWEEP_LAST = QW'(MAX_CHUNKS - 1);
    localparam logic [CHUNK_W-1:0] CHUNK_MIN  = CHUNK_W'(HEADER_BYTES + 1);
    localparam logic [CHUNK_W-1:0] HDR_C      = CHUNK_W'(HEADER_BYTES);
    localparam logic [ADDR_W-1:0]  HDR_A      = ADDR_W'(HEADER_BYTES);

    // configuration
    logic [ADDR_W-1:0]  pool_base_reg;
    logic [CHUNK_W-1:0] chunk_bytes_reg;
    logic [COUNT_W-1:0] pool_chunks_reg;

    // control
    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [QW-1:0]      sweep_reg, sweep_next;
    logic               rsp_valid_reg, rsp_valid_next;

    // payload / working registers
    logic               kind_reg, kind_next;
    status_t            status_reg, status_next;
    logic [ADDR_W-1:0]  acc_reg, acc_next;
    logic [QW-1:0]      quo_reg, quo_next;
    logic [QW-1:0]      mul_reg, mul_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    rsp_t               rsp_reg, rsp_next;

    // link memory
    logic [IDX_W-1:0]   link_mem [MAX_CHUNKS];
    logic [IDX_W-1:0]   rd_data_reg;
    logic               mem_we;
    logic [QW-1:0]      mem_waddr;
    logic [IDX_W-1:0]   mem_wdata;
    logic               mem_re;

    // derived values
    logic [CHUNK_W-1:0] chunk_eff;
    logic [CMP_W-1:0]   count_cmp;
    logic [IDX_W-1:0]   count_eff;
    logic               cfg_wr;
    logic [1:0]         cfg_idx;
    logic               relink;
    logic               accept;
    logic               too_large;
    logic               exhausted;
    logic [IDX_W-1:0]   sweep_link;
    logic               calc_done;
    logic               fin_go;
    logic               free_ok;

    // shared add/subtract unit
    logic [ADDR_W-1:0]  shifted;
    logic               unit_sub;
    logic [ADDR_W:0]    unit_sum;
    logic               unit_ge;

    //--------------------------------------------------------------------
    // APB
    //--------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign relink  = cfg_wr && ((cfg_idx == REG_CHUNK_BYTES) ||
                                (cfg_idx == REG_POOL_CHUNKS));

    always_comb
    begin
        unique case (cfg_idx)
            REG_POOL_BASE:   prdata = pool_base_reg;
            REG_CHUNK_BYTES: prdata = 32'(chunk_bytes_reg);
            REG_POOL_CHUNKS: prdata = 32'(pool_chunks_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg   <= '0;
            chunk_bytes_reg <= CHUNK_RST;
            pool_chunks_reg <= COUNT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_POOL_BASE:   pool_base_reg   <= pwdata;
                REG_CHUNK_BYTES: chunk_bytes_reg <= pwdata[CHUNK_W-1:0];
                REG_POOL_CHUNKS: pool_chunks_reg <= pwdata[COUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // out-of-range settings are clamped
    always_comb
    begin
        if (chunk_bytes_reg < CHUNK_MIN)
            chunk_eff = CHUNK_MIN;
        else if (chunk_bytes_reg > CHUNK_MAX)
            chunk_eff = CHUNK_MAX;
        else
            chunk_eff = chunk_bytes_reg;

        if (pool_chunks_reg == '0)
            count_cmp = CMP_W'(1);
        else if (CMP_W'(pool_chunks_reg) > CMP_W'(MAX_CHUNKS))
            count_cmp = CMP_W'(MAX_CHUNKS);
        else
            count_cmp = CMP_W'(pool_chunks_reg);
        count_eff = IDX_W'(count_cmp);
    end

    //--------------------------------------------------------------------
    // Request decode
    //--------------------------------------------------------------------
    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid & req_ready;
    assign too_large = (req.req_size > (chunk_eff - HDR_C));
    assign exhausted = (head_reg >= count_eff) || (head_reg >= NULL_LINK);

    //--------------------------------------------------------------------
    // Shared unit: add for the grant multiply, subtract for the divide
    //--------------------------------------------------------------------
    assign shifted  = ADDR_W'(chunk_eff) << step_reg;
    assign unit_sub = (kind_reg == KIND_FREE);
    assign unit_sum = {1'b0, acc_reg} + {1'b0, (unit_sub ? ~shifted : shifted)}
                      + (ADDR_W + 1)'(unit_sub);
    assign unit_ge  = unit_sum[ADDR_W];

    // free: the top step only checks that the quotient fits QW bits
    assign calc_done = (step_reg == '0) ||
                       (unit_sub && (step_reg == STEP_W'(QW)) && unit_ge);

    assign fin_go  = (state_reg == S_FINISH) && (!rsp_valid_reg || rsp_ready);
    assign free_ok = (status_reg == ST_OK) && (acc_reg == '0) &&
                     (IDX_W'(quo_reg) < count_eff);

    assign sweep_link = ((IDX_W'(sweep_reg) + IDX_W'(1)) < count_eff) ?
                        (IDX_W'(sweep_reg) + IDX_W'(1)) : NULL_LINK;

    //--------------------------------------------------------------------
    // Sequencer: next state
    //--------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_SWEEP:
                if (sweep_reg == SWEEP_LAST)
                    state_next = S_IDLE;
            S_IDLE:
                if (accept)
                begin
                    if (req.kind == KIND_FREE)
                        state_next = S_CALC;
                    else if (too_large || exhausted)
                        state_next = S_FINISH;
                    else
                        state_next = S_CALC;
                end
            S_CALC:
                if (calc_done)
                    state_next = S_FINISH;
            S_FINISH:
                if (fin_go)
                    state_next = S_IDLE;
            default:
                state_next = S_SWEEP;
        endcase
        if (relink)
            state_next = S_SWEEP;
    end

    //--------------------------------------------------------------------
    // Sequencer: datapath controls
    //--------------------------------------------------------------------
    always_comb
    begin
        head_next      = head_reg;
        sweep_next     = sweep_reg;
        rsp_valid_next = rsp_valid_reg;
        kind_next      = kind_reg;
        status_next    = status_reg;
        acc_next       = acc_reg;
        quo_next       = quo_reg;
        mul_next       = mul_reg;
        step_next      = step_reg;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_waddr      = sweep_reg;
        mem_wdata      = sweep_link;
        mem_re         = 1'b0;

        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;

        unique case (state_reg)
            S_SWEEP:
            begin
                mem_we     = 1'b1;
                sweep_next = sweep_reg + QW'(1);
            end
            S_IDLE:
                if (accept)
                begin
                    kind_next   = req.kind;
                    status_next = ST_OK;
                    quo_next    = '0;
                    mul_next    = head_reg[QW-1:0];
                    if (req.kind == KIND_FREE)
                    begin
                        acc_next  = req.address - pool_base_reg - HDR_A;
                        step_next = STEP_W'(QW);
                    end
                    else
                    begin
                        acc_next  = pool_base_reg + HDR_A;
                        step_next = STEP_W'(QW - 1);
                        mem_re    = 1'b1;
                        if (too_large)
                            status_next = ST_TOO_LARGE;
                        else if (exhausted)
                            status_next = ST_EXHAUSTED;
                    end
                end
            S_CALC:
            begin
                step_next = step_reg - STEP_W'(1);
                if (unit_sub)
                begin
                    if (step_reg == STEP_W'(QW))
                    begin
                        if (unit_ge)
                            status_next = ST_BAD_ADDR;
                    end
                    else
                    begin
                        if (unit_ge)
                            acc_next = unit_sum[ADDR_W-1:0];
                        quo_next = QW'({quo_reg, unit_ge});
                    end
                end
                else
                begin
                    if (mul_reg[QW-1])
                        acc_next = unit_sum[ADDR_W-1:0];
                    mul_next = mul_reg << 1;
                end
            end
            S_FINISH:
                if (fin_go)
                begin
                    rsp_valid_next = 1'b1;
                    if (kind_reg == KIND_FREE)
                    begin
                        rsp_next.status          = free_ok ? ST_OK : ST_BAD_ADDR;
                        rsp_next.granted_address = '0;
                        if (free_ok)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = quo_reg;
                            mem_wdata = head_reg;
                            head_next = IDX_W'(quo_reg);
                        end
                    end
                    else
                    begin
                        rsp_next.status = status_reg;
                        if (status_reg == ST_OK)
                        begin
                            rsp_next.granted_address = acc_reg;
                            head_next                = rd_data_reg;
                        end
                        else
                        begin
                            rsp_next.granted_address = '0;
                        end
                    end
                end
            default: ;
        endcase

        if (relink)
        begin
            sweep_next = '0;
            head_next  = '0;
        end
    end

    //--------------------------------------------------------------------
    // Registers
    //--------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            head_reg      <= '0;
            sweep_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            sweep_reg     <= sweep_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        status_reg <= status_next;
        acc_reg    <= acc_next;
        quo_reg    <= quo_next;
        mul_reg    <= mul_next;
        step_reg   <= step_next;
        rsp_reg    <= rsp_next;
    end

    // link store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            link_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= link_mem[head_reg[QW-1:0]];
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== rtl/fbpa_checker.sv =====
// Port-level checker for the pool allocator, bound to the top level
`timescale 1ns / 1ps
`include "fixed_block_pool_allocator_top_assert.svh"

module fbpa_checker
    import fbpa_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input rsp_t               rsp,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic               pready,
    input logic [PADDR_W-1:0] paddr
);

    logic relink_wr;

    assign relink_wr = psel && penable && pwrite && pready &&
                       ((paddr[3:2] == REG_CHUNK_BYTES) || (paddr[3:2] == REG_POOL_CHUNKS));

    // a stalled response holds
    `FBPA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

    // only a successful allocate carries an address
    `FBPA_ASSERT_IMPL(a_grant_zero, rsp_valid && (rsp.status != ST_OK), rsp.granted_address == '0)

    // one request at a time
    `FBPA_ASSERT_NEXT(a_one_busy, req_valid && req_ready, !req_ready)

    // a relink write starts the sweep
    `FBPA_ASSERT_NEXT(a_relink_busy, relink_wr, !req_ready)

endmodule

bind fixed_block_pool_allocator_top fbpa_checker u_fbpa_checker (.*);

// ===== tb/tb_fixed_block_pool_allocator_top.sv =====
// Self-checking testbench for the fixed block pool allocator
`timescale 1ns / 1ps

module tb_fixed_block_pool_allocator_top
    import fbpa_pkg::*;
();

    localparam int HDR  = 8;
    localparam int MAXC = 256;
    // address 0xC decodes to no register; writes there must change nothing
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef enum logic { ROW_WRITE, ROW_ITEM } row_kind_t;

    // one line of the directed plan: either a register write or a request
    typedef struct {
        row_kind_t   what;
        logic [1:0]  reg_idx;
        logic [31:0] value;
        req_t        item;
        bit          typed;
        rsp_t        want;
    } row_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    req_t               req       = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b1;
    rsp_t               rsp;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [31:0]        pwdata    = '0;
    logic [31:0]        prdata;
    logic               pready;

    // typed expectation that travels with the request being offered
    bit                 row_typed = 1'b0;
    rsp_t               row_want  = '0;

    // shadow of the allocator: registers, link table and list head
    logic [31:0]        cfg_base;
    logic [12:0]        cfg_chunk;
    logic [8:0]         cfg_count;
    logic [8:0]         links [MAXC];
    logic [8:0]         head;

    rsp_t               awaited_rsp [$];   // responses still owed by the block
    logic [31:0]        held_addr [$];     // addresses granted and not yet freed
    row_t               plan [$];
    bit                 idle_on = 1'b1;    // random gaps on both channels
    int                 errors  = 0;
    int                 stall_left = 0;

    fixed_block_pool_allocator_top #(
        .MAX_CHUNKS   (MAXC),
        .HEADER_BYTES (HDR)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    task automatic report_error(input string msg);
        $display("%0t ERROR %s", $time, msg);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------

    // chunk size and count as the block uses them (out-of-range writes clamp)
    function automatic int unsigned eff_chunk();
        if (cfg_chunk < HDR + 1)
            return HDR + 1;
        if (cfg_chunk > CHUNK_MAX)
            return 32'(CHUNK_MAX);
        return 32'(cfg_chunk);
    endfunction

    function automatic int unsigned eff_count();
        if (cfg_count < 1)
            return 1;
        if (cfg_count > MAXC)
            return MAXC;
        return 32'(cfg_count);
    endfunction

    // every chunk free again, in ascending order; null link is MAXC
    function automatic void pool_relink();
        int unsigned n;
        n = eff_count();
        for (int i = 0; i < MAXC; i++)
            links[i] = (i + 1 < n) ? 9'(i + 1) : 9'(MAXC);
        head = '0;
    endfunction

    function automatic void pool_config(input logic [1:0] idx, input logic [31:0] val);
        case (idx)
            REG_POOL_BASE:   cfg_base = val;
            REG_CHUNK_BYTES:
            begin
                cfg_chunk = val[12:0];
                pool_relink();
            end
            REG_POOL_CHUNKS:
            begin
                cfg_count = val[8:0];
                pool_relink();
            end
            default: ;
        endcase
        // old grants no longer line up once the base or the layout moves
        held_addr.delete();
    endfunction

    // response for one request, updating the free list as the block would
    function automatic rsp_t pool_apply(input req_t r);
        int unsigned csz;
        int unsigned cnt;
        int unsigned off;
        int unsigned idx;
        rsp_t        o;
        csz = eff_chunk();
        cnt = eff_count();
        o.status = ST_OK;
        o.granted_address = '0;
        if (r.kind == KIND_ALLOC)
        begin
            // size is checked before the list is looked at
            if (r.req_size > csz - HDR)
                o.status = ST_TOO_LARGE;
            else if (head >= cnt)
                o.status = ST_EXHAUSTED;
            else
            begin
                idx = 32'(head);
                head = links[idx];
                o.granted_address = cfg_base + idx * csz + HDR;
            end
        end
        else
        begin
            // modulo 2^32, so pools across the top of memory wrap
            off = r.address - HDR - cfg_base;
            if (off >= cnt * csz || off % csz != 0)
                o.status = ST_BAD_ADDR;
            else
            begin
                // no double-free detection: the chunk is pushed regardless
                idx = off / csz;
                links[idx] = head;
                head = 9'(idx);
            end
        end
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Plan rows
    // ------------------------------------------------------------------

    function automatic row_t row_item(input logic kind, input int unsigned size,
                                      input logic [31:0] addr);
        row_t r;
        r.what = ROW_ITEM;
        r.reg_idx = '0;
        r.value = '0;
        r.item.kind = kind;
        r.item.req_size = size[12:0];
        r.item.address = addr;
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic row_t row_check(input logic kind, input int unsigned size,
                                       input logic [31:0] addr, input status_t st,
                                       input logic [31:0] grant);
        row_t r;
        r = row_item(kind, size, addr);
        r.typed = 1'b1;
        r.want = '{status: st, granted_address: grant};
        return r;
    endfunction

    function automatic row_t row_write(input logic [1:0] idx, input logic [31:0] val);
        row_t r;
        r = row_item(KIND_ALLOC, 0, '0);
        r.what = ROW_WRITE;
        r.reg_idx = idx;
        r.value = val;
        return r;
    endfunction

    // random request: mostly sane allocates and frees of live grants,
    // some oversize sizes, double frees, misaligned and wild addresses
    function automatic req_t pick_request();
        req_t        r;
        int unsigned roll;
        int unsigned csz;
        int unsigned cnt;
        int unsigned slot;
        csz = eff_chunk();
        cnt = eff_count();
        r.kind = KIND_ALLOC;
        r.req_size = 13'($urandom);
        r.address = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            r.req_size = 13'($urandom_range(0, csz - HDR));
        else if (roll >= 55)
        begin
            r.kind = KIND_FREE;
            if (roll < 80 && held_addr.size() != 0)
            begin
                slot = $urandom_range(0, held_addr.size() - 1);
                r.address = held_addr[slot];
                held_addr.delete(slot);
            end
            else if (roll < 90)
                r.address = cfg_base + $urandom_range(0, cnt - 1) * csz + HDR;
            else if (roll < 95)
                r.address = cfg_base + $urandom_range(0, cnt) * csz + HDR
                            + $urandom_range(0, 2) - 1;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers (all at the rising edge, nonblocking)
    // ------------------------------------------------------------------

    // offer one request; returns at the edge that accepted it
    task automatic send_item(input req_t r, input bit typed, input rsp_t want);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        row_typed <= typed;
        row_want  <= want;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    // stop offering and let every owed response come back
    task automatic wait_quiet();
        req_valid <= 1'b0;
        @(posedge clk);
        while (awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write: setup, access, then idle before the next transfer
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pool_config(idx, val);
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Monitors
    // ------------------------------------------------------------------

    // accepted request: run the shadow and queue what the block owes
    always @(posedge clk)
    begin : req_side
        rsp_t model_rsp;
        if (rst_n && req_valid && req_ready)
        begin
            model_rsp = pool_apply(req);
            if (req.kind == KIND_ALLOC && model_rsp.status == ST_OK)
                held_addr.push_back(model_rsp.granted_address);
            awaited_rsp.push_back(row_typed ? row_want : model_rsp);
        end
    end

    // accepted response: compare with the oldest owed one, then maybe stall
    always @(posedge clk)
    begin : rsp_side
        rsp_t want;
        int   draw;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (awaited_rsp.size() == 0)
                report_error($sformatf("response with none owed: status %0d addr %h",
                                       rsp.status, rsp.granted_address));
            else
            begin
                want = awaited_rsp.pop_front();
                if (rsp.status !== want.status)
                    report_error($sformatf("status %0d, expected %0d",
                                           rsp.status, want.status));
                if (rsp.granted_address !== want.granted_address)
                    report_error($sformatf("address %h, expected %h",
                                           rsp.granted_address, want.granted_address));
            end
            draw = idle_on ? $urandom_range(0, 5) : 0;
            if (draw > 0)
            begin
                rsp_ready  <= 1'b0;
                stall_left <= draw;
            end
        end
        else if (rst_n && !rsp_ready)
        begin
            if (stall_left <= 1)
                rsp_ready <= 1'b1;
            stall_left <= stall_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial
    begin
        row_t row;

        cfg_base  = '0;
        cfg_chunk = CHUNK_RST;
        cfg_count = COUNT_RST;
        pool_relink();

        // reset layout: base 0, 64-byte chunks, 256 of them
        plan.push_back(row_check(KIND_ALLOC, 0, '0, ST_OK, 32'h8));
        plan.push_back(row_check(KIND_ALLOC, 56, '0, ST_OK, 32'h48));   // largest fit
        plan.push_back(row_check(KIND_ALLOC, 57, '0, ST_TOO_LARGE, '0));
        plan.push_back(row_check(KIND_ALLOC, 8191, '0, ST_TOO_LARGE, '0));
        plan.push_back(row_check(KIND_FREE, 0, 32'h8, ST_OK, '0));
        plan.push_back(row_check(KIND_FREE, 8191, 32'h9, ST_BAD_ADDR, '0));   // misaligned
        plan.push_back(row_check(KIND_FREE, 0, 32'h0, ST_BAD_ADDR, '0));      // below pool
        plan.push_back(row_check(KIND_FREE, 0, 32'hFFFF_FFFF, ST_BAD_ADDR, '0));
        plan.push_back(row_check(KIND_FREE, 0, 32'h4008, ST_BAD_ADDR, '0));   // one past end
        plan.push_back(row_check(KIND_FREE, 0, 32'h3FC8, ST_OK, '0));         // free chunk again
        plan.push_back(row_item(KIND_ALLOC, 1, '0));
        plan.push_back(row_item(KIND_ALLOC, 56, 32'hFFFF_FFFF));

        // clamped minimum layout: one chunk of 9 bytes
        plan.push_back(row_write(REG_POOL_CHUNKS, 32'd0));
        plan.push_back(row_write(REG_CHUNK_BYTES, 32'd0));
        plan.push_back(row_write(REG_POOL_BASE, 32'h1000));
        plan.push_back(row_check(KIND_ALLOC, 1, '0, ST_OK, 32'h1008));
        plan.push_back(row_check(KIND_ALLOC, 2, '0, ST_TOO_LARGE, '0));   // size wins over empty
        plan.push_back(row_check(KIND_ALLOC, 0, '0, ST_EXHAUSTED, '0));
        plan.push_back(row_check(KIND_FREE, 0, 32'h1011, ST_BAD_ADDR, '0));
        plan.push_back(row_check(KIND_FREE, 0, 32'h1008, ST_OK, '0));

        // clamped maximum layout straddling the top of the address space
        plan.push_back(row_write(REG_POOL_BASE, 32'hFFFF_FFF0));
        plan.push_back(row_write(REG_CHUNK_BYTES, 32'h1FFF));
        plan.push_back(row_write(REG_POOL_CHUNKS, 32'h1FF));
        plan.push_back(row_check(KIND_ALLOC, 4088, '0, ST_OK, 32'hFFFF_FFF8));
        plan.push_back(row_check(KIND_ALLOC, 4089, '0, ST_TOO_LARGE, '0));
        plan.push_back(row_check(KIND_ALLOC, 0, '0, ST_OK, 32'h0000_0FF8));
        plan.push_back(row_check(KIND_FREE, 0, 32'h0000_0FF8, ST_OK, '0));

        // base moves without relink; the undecoded register is ignored
        plan.push_back(row_write(REG_POOL_BASE, 32'h0000_F000));
        plan.push_back(row_write(REG_UNUSED, 32'hFFFF_FFFF));
        plan.push_back(row_item(KIND_ALLOC, 0, '0));
        plan.push_back(row_item(KIND_FREE, 0, 32'hFFFF_FFF8));
        plan.push_back(row_item(KIND_FREE, 0, 32'h0000_F008));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            row = plan[i];
            if (row.what == ROW_WRITE)
            begin
                wait_quiet();
                reg_write(row.reg_idx, row.value);
            end
            else
                send_item(row.item, row.typed, row.want);
        end

        // random phases, each with a new base and mostly a fresh layout; every third runs flat out
        for (int phase = 0; phase < 8; phase++)
        begin
            wait_quiet();
            idle_on = (phase % 3) != 2;
            case ($urandom_range(0, 2))
                0:       reg_write(REG_POOL_BASE, $urandom);
                1:       reg_write(REG_POOL_BASE, 32'hFFFF_FFFF - $urandom_range(0, 65535));
                default: reg_write(REG_POOL_BASE, $urandom_range(0, 65535));
            endcase
            // now and then keep the list as it is and only move the base
            if (phase == 0 || $urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 5))
                    0:       reg_write(REG_CHUNK_BYTES, HDR + 1);
                    1:       reg_write(REG_CHUNK_BYTES, 32'(CHUNK_MAX));
                    2:       reg_write(REG_CHUNK_BYTES, $urandom_range(0, HDR));
                    3:       reg_write(REG_CHUNK_BYTES, $urandom_range(4097, 8191));
                    default: reg_write(REG_CHUNK_BYTES, $urandom_range(HDR + 1, 200));
                endcase
                // small pools mostly, so the list runs dry often
                case ($urandom_range(0, 5))
                    0:       reg_write(REG_POOL_CHUNKS, 0);
                    1:       reg_write(REG_POOL_CHUNKS, MAXC);
                    2:       reg_write(REG_POOL_CHUNKS, $urandom_range(MAXC + 1, 511));
                    default: reg_write(REG_POOL_CHUNKS, $urandom_range(1, 12));
                endcase
            end
            repeat (88) send_item(pick_request(), 1'b0, '0);
        end

        wait_quiet();
        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
